// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop on every clock edge outside reset.
`define M3I_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that post holds in the cycle after pre.
`define M3I_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define M3I_ASSERT(lbl, clk, rst_n, prop, msg)
`define M3I_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- sv/m3i_pkg.sv -----
// ----------------------------------------------------------------------------
// m3i_pkg
// Widths, stage counts, cofactor operand tables and shared types.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int unsigned DIM      = 3;
    localparam int unsigned NE       = DIM * DIM;
    localparam int unsigned EW       = 32;           // Q16.16 element
    localparam int unsigned CW       = 2 * EW;       // cofactor, Q32.32
    localparam int unsigned PW       = 3 * EW;       // element times cofactor
    localparam int unsigned DW       = PW + 1;       // determinant sum
    localparam int unsigned DMW      = PW;           // determinant magnitude
    localparam int unsigned RW       = PW + 1;       // divider remainder
    localparam int unsigned QW       = EW;           // quotient bits
    localparam int unsigned NSTEP    = QW;           // one quotient bit per stage
    localparam int unsigned STG_PRE  = 9;            // stages ahead of the divider steps
    localparam int unsigned NSTG     = STG_PRE + NSTEP;
    localparam int unsigned M0DLY    = 2;
    localparam int unsigned CDLY     = 5;
    localparam int unsigned DM_STG   = NSTEP + 1;
    localparam int unsigned ZERO_STG = NSTG - 7;

    localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

    // Cofactor k = m[A]*m[B] - m[C]*m[D], elements indexed row-major
    localparam int unsigned COF_A [NE] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
    localparam int unsigned COF_B [NE] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
    localparam int unsigned COF_C [NE] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
    localparam int unsigned COF_D [NE] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

    typedef logic signed [EW-1:0] t_elem;
    typedef logic signed [CW-1:0] t_cof;
    typedef logic [DMW-1:0] t_dm;
    typedef logic [DM_STG-1:0][DMW-1:0] t_dm_line;

    typedef struct packed {
        t_dm  dm;
        logic neg;
        logic zero;
    } t_det;

    typedef struct packed {
        logic [NE-1:0][EW-1:0] r;
        logic                  singular;
    } t_res;

endpackage

// ----- sv/m3i_cof.sv -----
// ----------------------------------------------------------------------------
// m3i_cof
// One cofactor lane: two products, then their difference (exact, 64 bits).
// ----------------------------------------------------------------------------
module m3i_cof (
    input  logic                i_clk,
    input  logic                i_en,
    input  m3i_pkg::t_elem      i_a,
    input  m3i_pkg::t_elem      i_b,
    input  m3i_pkg::t_elem      i_c,
    input  m3i_pkg::t_elem      i_d,
    output m3i_pkg::t_cof       o_cof
);

    m3i_pkg::t_cof r_p;
    m3i_pkg::t_cof r_q;
    m3i_pkg::t_cof r_cof;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= m3i_pkg::CW'(i_a) * m3i_pkg::CW'(i_b);
            r_q   <= m3i_pkg::CW'(i_c) * m3i_pkg::CW'(i_d);
            r_cof <= r_p - r_q;
        end
    end

    assign o_cof = r_cof;

endmodule

// ----- sv/m3i_det.sv -----
// ----------------------------------------------------------------------------
// m3i_det
// Determinant by first-row expansion, then its magnitude, sign and zero flag.
// ----------------------------------------------------------------------------
module m3i_det (
    input  logic                i_clk,
    input  logic                i_en,
    input  m3i_pkg::t_elem      i_m0  [m3i_pkg::DIM],
    input  m3i_pkg::t_cof       i_cof0 [m3i_pkg::DIM],
    output m3i_pkg::t_det       o_det
);

    logic signed [m3i_pkg::EW*2:0]  r_lo   [m3i_pkg::DIM];
    logic signed [m3i_pkg::CW-1:0]  r_hi   [m3i_pkg::DIM];
    logic signed [m3i_pkg::PW-1:0]  r_prod [m3i_pkg::DIM];
    logic signed [m3i_pkg::DW-1:0]  r_s01;
    logic signed [m3i_pkg::PW-1:0]  r_p2;
    logic signed [m3i_pkg::DW-1:0]  r_d;
    logic signed [m3i_pkg::DW-1:0]  n_negd;
    m3i_pkg::t_det                  r_det;

    // Split the cofactor: unsigned low half, signed high half
    for (genvar j = 0; j < m3i_pkg::DIM; j++) begin : g_mul
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lo[j]   <= (2*m3i_pkg::EW+1)'(i_m0[j])
                           * (2*m3i_pkg::EW+1)'($signed({1'b0,
                                                 i_cof0[j][m3i_pkg::EW-1:0]}));
                r_hi[j]   <= m3i_pkg::CW'(i_m0[j])
                           * m3i_pkg::CW'($signed(i_cof0[j][m3i_pkg::CW-1:m3i_pkg::EW]));
                r_prod[j] <= $signed({r_hi[j], {m3i_pkg::EW{1'b0}}})
                           + $signed({{(m3i_pkg::PW-2*m3i_pkg::EW-1){r_lo[j][2*m3i_pkg::EW]}},
                                      r_lo[j]});
            end
        end
    end

    assign n_negd = -r_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s01      <= {r_prod[0][m3i_pkg::PW-1], r_prod[0]}
                        + {r_prod[1][m3i_pkg::PW-1], r_prod[1]};
            r_p2       <= r_prod[2];
            r_d        <= r_s01 + {r_p2[m3i_pkg::PW-1], r_p2};
            r_det.neg  <= r_d[m3i_pkg::DW-1];
            r_det.zero <= (r_d == '0);
            r_det.dm   <= r_d[m3i_pkg::DW-1] ? n_negd[m3i_pkg::DMW-1:0]
                                             : r_d[m3i_pkg::DMW-1:0];
        end
    end

    assign o_det = r_det;

endmodule

// ----- sv/m3i_div.sv -----
// ----------------------------------------------------------------------------
// m3i_div
// Divider lane: |cofactor| * 2^32 / |det|, one quotient bit per stage,
// then sign and Q16.16 saturation.
// ----------------------------------------------------------------------------
module m3i_div (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  m3i_pkg::t_cof           i_cof,
    input  logic                    i_dneg,
    input  m3i_pkg::t_dm_line       i_dm,
    output logic [m3i_pkg::EW-1:0]  o_q
);

    m3i_pkg::t_cof                 n_negc;
    logic [m3i_pkg::CW-2:0]        r_cm;
    logic                          r_neg0;
    logic [m3i_pkg::RW-1:0]        r_rem [m3i_pkg::NSTEP+1];
    logic [m3i_pkg::QW-1:0]        r_q   [m3i_pkg::NSTEP+1];
    logic                          r_neg [m3i_pkg::NSTEP+1];
    logic                          r_big [m3i_pkg::NSTEP+1];
    logic [m3i_pkg::QW-1:0]        w_qf;

    assign n_negc = -i_cof;

    // Magnitude and result sign; overflow when |c| >= |d|
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cm     <= i_cof[m3i_pkg::CW-1] ? n_negc[m3i_pkg::CW-2:0]
                                             : i_cof[m3i_pkg::CW-2:0];
            r_neg0   <= i_cof[m3i_pkg::CW-1] ^ i_dneg;
            r_rem[0] <= m3i_pkg::RW'(r_cm);
            r_q[0]   <= '0;
            r_neg[0] <= r_neg0;
            r_big[0] <= (m3i_pkg::DMW'(r_cm) >= i_dm[0]);
        end
    end

    for (genvar k = 0; k < m3i_pkg::NSTEP; k++) begin : g_step
        logic [m3i_pkg::RW-1:0] w_dbl;
        logic [m3i_pkg::RW:0]   w_dif;
        logic                   w_ge;

        assign w_dbl = {r_rem[k][m3i_pkg::RW-2:0], 1'b0};
        assign w_dif = {1'b0, w_dbl} - (m3i_pkg::RW+1)'(i_dm[k+1]);
        assign w_ge  = ~w_dif[m3i_pkg::RW];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? w_dif[m3i_pkg::RW-1:0] : w_dbl;
                r_q[k+1]   <= {r_q[k][m3i_pkg::QW-2:0], w_ge};
                r_neg[k+1] <= r_neg[k];
                r_big[k+1] <= r_big[k];
            end
        end
    end

    assign w_qf = r_q[m3i_pkg::NSTEP];

    always_comb begin
        if (r_neg[m3i_pkg::NSTEP]) begin
            if (r_big[m3i_pkg::NSTEP] || (w_qf > m3i_pkg::SAT_NEG)) begin
                o_q = m3i_pkg::SAT_NEG;
            end else begin
                o_q = -w_qf;
            end
        end else begin
            if (r_big[m3i_pkg::NSTEP] || w_qf[m3i_pkg::QW-1]) begin
                o_q = m3i_pkg::SAT_POS;
            end else begin
                o_q = w_qf;
            end
        end
    end

endmodule

// ----- sv/matrix3_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix3_inverse
// Path: cofactor lanes, determinant, divider lanes, then the output register.
// Throughput: one matrix per cycle while the skid stage is empty, set by the
//   32-stage divider lanes, one quotient bit per stage in nine parallel lanes.
// Reset: synchronous, active low; clears the valid line and the output and
//   skid flags. No clearing pass, the block is ready at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix3_inverse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_m00,
    input  logic signed [31:0] i_m01,
    input  logic signed [31:0] i_m02,
    input  logic signed [31:0] i_m10,
    input  logic signed [31:0] i_m11,
    input  logic signed [31:0] i_m12,
    input  logic signed [31:0] i_m20,
    input  logic signed [31:0] i_m21,
    input  logic signed [31:0] i_m22,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_r00,
    output logic signed [31:0] o_r01,
    output logic signed [31:0] o_r02,
    output logic signed [31:0] o_r10,
    output logic signed [31:0] o_r11,
    output logic signed [31:0] o_r12,
    output logic signed [31:0] o_r20,
    output logic signed [31:0] o_r21,
    output logic signed [31:0] o_r22,
    output logic               o_singular
);

    m3i_pkg::t_elem              w_m     [m3i_pkg::NE];
    m3i_pkg::t_cof               w_cof   [m3i_pkg::NE];
    m3i_pkg::t_cof               w_cof0  [m3i_pkg::DIM];
    m3i_pkg::t_elem              r_m0    [m3i_pkg::M0DLY][m3i_pkg::DIM];
    m3i_pkg::t_cof               r_cofd  [m3i_pkg::CDLY][m3i_pkg::NE];
    m3i_pkg::t_det               w_det;
    m3i_pkg::t_dm_line           r_dm;
    logic [m3i_pkg::ZERO_STG-1:0] r_zero;
    logic [m3i_pkg::EW-1:0]      w_q     [m3i_pkg::NE];
    logic [m3i_pkg::NSTG-1:0]    r_vld;
    m3i_pkg::t_res               w_res;
    m3i_pkg::t_res               r_out;
    m3i_pkg::t_res               r_skid;
    logic                        r_out_vld;
    logic                        r_skid_vld;
    logic                        n_out_vld;
    logic                        n_skid_vld;
    logic                        w_en;
    logic                        w_push;
    logic                        w_ld_out;
    logic                        w_ld_skid;
    logic                        w_out_from_skid;

    // The whole pipeline advances while the skid stage is empty, so a new
    // transaction is taken even when a finished result is held at the output.
    assign w_en    = ~r_skid_vld;
    assign o_stall = r_skid_vld;
    assign w_push  = w_en & r_vld[m3i_pkg::NSTG-1];

    assign w_m[0] = i_m00;
    assign w_m[1] = i_m01;
    assign w_m[2] = i_m02;
    assign w_m[3] = i_m10;
    assign w_m[4] = i_m11;
    assign w_m[5] = i_m12;
    assign w_m[6] = i_m20;
    assign w_m[7] = i_m21;
    assign w_m[8] = i_m22;

    // Nine cofactor lanes, each a difference of two element products
    for (genvar g = 0; g < m3i_pkg::NE; g++) begin : g_cof
        m3i_cof u_cof (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_m[m3i_pkg::COF_A[g]]),
            .i_b   (w_m[m3i_pkg::COF_B[g]]),
            .i_c   (w_m[m3i_pkg::COF_C[g]]),
            .i_d   (w_m[m3i_pkg::COF_D[g]]),
            .o_cof (w_cof[g])
        );
    end

    for (genvar j = 0; j < m3i_pkg::DIM; j++) begin : g_row0
        assign w_cof0[j] = w_cof[j];
    end

    // Hold the first row alongside the cofactor stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m0[0] <= '{i_m00, i_m01, i_m02};
            r_m0[1] <= r_m0[0];
        end
    end

    m3i_det u_det (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_m0   (r_m0[m3i_pkg::M0DLY-1]),
        .i_cof0 (w_cof0),
        .o_det  (w_det)
    );

    // Delay cofactors to meet the determinant; carry |det| and the zero
    // flag along the divider stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cofd[0] <= w_cof;
            for (int k = 1; k < m3i_pkg::CDLY; k++) begin
                r_cofd[k] <= r_cofd[k-1];
            end
            r_dm   <= {r_dm[m3i_pkg::DM_STG-2:0], w_det.dm};
            r_zero <= {r_zero[m3i_pkg::ZERO_STG-2:0], w_det.zero};
        end
    end

    // Divider lanes: output (row, column) takes the cofactor (column, row)
    for (genvar g = 0; g < m3i_pkg::NE; g++) begin : g_div
        m3i_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_cof  (r_cofd[m3i_pkg::CDLY-1][(g % m3i_pkg::DIM) * m3i_pkg::DIM
                                             + g / m3i_pkg::DIM]),
            .i_dneg (w_det.neg),
            .i_dm   (r_dm),
            .o_q    (w_q[g])
        );
    end

    // Merge the lanes; a zero determinant forces every element to zero
    always_comb begin
        w_res.singular = r_zero[m3i_pkg::ZERO_STG-1];
        for (int g = 0; g < m3i_pkg::NE; g++) begin
            w_res.r[g] = w_res.singular ? '0 : w_q[g];
        end
    end

    // Output register with a skid stage behind it
    always_comb begin
        w_out_from_skid = 1'b0;
        w_ld_out        = 1'b0;
        w_ld_skid       = 1'b0;
        n_out_vld       = r_out_vld;
        n_skid_vld      = r_skid_vld;
        if (!r_out_vld || !i_stall) begin
            if (r_skid_vld) begin
                w_out_from_skid = 1'b1;
                n_out_vld       = 1'b1;
                n_skid_vld      = 1'b0;
            end else begin
                w_ld_out  = w_push;
                n_out_vld = w_push;
            end
        end else if (w_push) begin
            w_ld_skid  = 1'b1;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[m3i_pkg::NSTG-2:0], i_valid};
            end
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_from_skid) begin
            r_out <= r_skid;
        end else if (w_ld_out) begin
            r_out <= w_res;
        end
        if (w_ld_skid) begin
            r_skid <= w_res;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_singular = r_out.singular;
    assign o_r00      = $signed(r_out.r[0]);
    assign o_r01      = $signed(r_out.r[1]);
    assign o_r02      = $signed(r_out.r[2]);
    assign o_r10      = $signed(r_out.r[3]);
    assign o_r11      = $signed(r_out.r[4]);
    assign o_r12      = $signed(r_out.r[5]);
    assign o_r20      = $signed(r_out.r[6]);
    assign o_r21      = $signed(r_out.r[7]);
    assign o_r22      = $signed(r_out.r[8]);

    `M3I_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld |-> r_out_vld, "skid full with output empty")
    `M3I_ASSERT_NEXT(a_stalled_push_skid, i_clk, i_rst_n, r_out_vld && i_stall && r_vld[m3i_pkg::NSTG-1] && !r_skid_vld, r_skid_vld, "stalled result not caught by skid")
    `M3I_ASSERT_NEXT(a_push_to_empty, i_clk, i_rst_n, !r_out_vld && !r_skid_vld && r_vld[m3i_pkg::NSTG-1], r_out_vld, "finished result not loaded into empty output")
    `M3I_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0], "accepted transaction missing from first stage")
    `M3I_ASSERT(a_singular_zero, i_clk, i_rst_n, (o_valid && o_singular) |-> (o_r00 == 0) && (o_r01 == 0) && (o_r02 == 0) && (o_r10 == 0) && (o_r11 == 0) && (o_r12 == 0) && (o_r20 == 0) && (o_r21 == 0) && (o_r22 == 0), "singular result with non-zero element")

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for matrix3_inverse
// Streams 3x3 Q16.16 matrices through the inverter and checks every result
// against a predictor working on exact wide integers: cofactors, determinant
// and one truncating division per element, with saturation and singular flag.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        m3i_pkg::t_elem m [m3i_pkg::NE];
        bit             hold;    // wait until every result is back before offering
    } t_matrix;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    m3i_pkg::t_elem i_m [m3i_pkg::NE];
    logic           o_valid;
    logic           i_stall;
    m3i_pkg::t_elem o_r [m3i_pkg::NE];
    logic           o_singular;

    t_matrix        pending_mats [$];
    m3i_pkg::t_res  inverse_q [$];
    int          n_taken;
    int          n_checked;
    int          n_singular;
    int          n_saturated;
    int          n_errors;
    int          send_gap;
    int          recv_gap;
    int          hold_off_left;
    bit          hold_off_done;
    bit          calm;

    matrix3_inverse dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_m00      (i_m[0]),
        .i_m01      (i_m[1]),
        .i_m02      (i_m[2]),
        .i_m10      (i_m[3]),
        .i_m11      (i_m[4]),
        .i_m12      (i_m[5]),
        .i_m20      (i_m[6]),
        .i_m21      (i_m[7]),
        .i_m22      (i_m[8]),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_r00      (o_r[0]),
        .o_r01      (o_r[1]),
        .o_r02      (o_r[2]),
        .o_r10      (o_r[3]),
        .o_r11      (o_r[4]),
        .o_r12      (o_r[5]),
        .o_r20      (o_r[6]),
        .o_r21      (o_r[7]),
        .o_r22      (o_r[8]),
        .o_singular (o_singular)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Quotient of one cofactor by the determinant magnitude, in Q16.16.
    // The cofactor is Q32.32, the determinant Q48.48, hence the shift by 32.
    function automatic logic [31:0] scaled_div(logic signed [63:0] cof,
                                               logic [127:0] det_mag, bit det_neg);
        logic [127:0] num;
        logic [127:0] quo;
        bit           neg;
        num = (cof < 0) ? 128'(-cof) : 128'(cof);
        num = num << 32;
        quo = num / det_mag;
        neg = (cof < 0) != det_neg;
        if (neg) begin
            if (quo > 128'h8000_0000) return m3i_pkg::SAT_NEG;
            return 32'(-quo);
        end
        if (quo > 128'h7FFF_FFFF) return m3i_pkg::SAT_POS;
        return quo[31:0];
    endfunction

    // Exact adjugate over determinant; all zeros and the flag when singular.
    function automatic m3i_pkg::t_res invert(m3i_pkg::t_elem m [m3i_pkg::NE]);
        logic signed [63:0]  cof [m3i_pkg::NE];
        logic signed [127:0] det;
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic [127:0]        det_mag;
        m3i_pkg::t_res       res;
        cof[0] = m[4] * m[8] - m[5] * m[7];
        cof[1] = m[5] * m[6] - m[3] * m[8];
        cof[2] = m[3] * m[7] - m[4] * m[6];
        cof[3] = m[2] * m[7] - m[1] * m[8];
        cof[4] = m[0] * m[8] - m[2] * m[6];
        cof[5] = m[1] * m[6] - m[0] * m[7];
        cof[6] = m[1] * m[5] - m[2] * m[4];
        cof[7] = m[2] * m[3] - m[0] * m[5];
        cof[8] = m[0] * m[4] - m[1] * m[3];
        det = '0;
        for (int j = 0; j < m3i_pkg::DIM; j++) begin
            a = m[j];
            b = cof[j];
            det += a * b;
        end
        res = '0;
        if (det == 0) begin
            res.singular = 1'b1;
            return res;
        end
        det_mag = (det < 0) ? 128'(-det) : 128'(det);
        // transpose: result row i, column j takes cofactor (j, i)
        for (int i = 0; i < m3i_pkg::DIM; i++)
            for (int j = 0; j < m3i_pkg::DIM; j++)
                res.r[i*m3i_pkg::DIM+j] = scaled_div(cof[j*m3i_pkg::DIM+i], det_mag,
                                                     det < 0);
        return res;
    endfunction

    function automatic m3i_pkg::t_elem rand_elem(int kind);
        case (kind)
            0: return m3i_pkg::t_elem'($urandom);
            1: return m3i_pkg::t_elem'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            2: return m3i_pkg::t_elem'(($urandom_range(0, 8) - 4) * 32'sh0001_0000);
            default: return m3i_pkg::t_elem'($urandom_range(0, 32'h0000_0400)) - 32'sh200;
        endcase
    endfunction

    task automatic add_diag(m3i_pkg::t_elem d0, m3i_pkg::t_elem d1, m3i_pkg::t_elem d2,
                            m3i_pkg::t_elem off);
        t_matrix mt;
        foreach (mt.m[k]) mt.m[k] = off;
        mt.m[0] = d0;
        mt.m[4] = d1;
        mt.m[8] = d2;
        mt.hold = 1'b0;
        pending_mats.push_back(mt);
    endtask

    task automatic add_random(int kind);
        t_matrix mt;
        int      ek;
        bit      flip;
        ek = (kind == 4) ? $urandom_range(0, 3) : kind;
        flip = $urandom_range(0, 1);
        foreach (mt.m[k]) mt.m[k] = rand_elem(ek);
        if (kind == 4) begin
            // make the last row a copy or the negation of the first: singular
            for (int j = 0; j < m3i_pkg::DIM; j++)
                mt.m[6+j] = flip ? -mt.m[j] : mt.m[j];
        end
        mt.hold = 1'b0;
        pending_mats.push_back(mt);
    endtask

    initial begin
        t_matrix mt;
        i_rst_n = 1'b0;

        // directed: singular zero, identities, extremes and saturation edges
        add_diag(0, 0, 0, 0);
        add_diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0);
        add_diag(-32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000, 0);
        add_diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
        add_diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
        add_diag(1, 1, 1, 0);                    // huge inverse: positive saturation
        add_diag(-1, 32'sh0001_0000, 1, 0);      // negative saturation
        add_diag(-2, -2, -2, 0);                 // exactly the most negative value
        add_diag(2, 2, 2, 0);                    // one above the largest value
        add_diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        add_diag(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        add_diag(32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0000_8000);
        // permutation matrix
        foreach (mt.m[k]) mt.m[k] = 0;
        mt.m[1] = 32'sh0001_0000;
        mt.m[5] = 32'sh0001_0000;
        mt.m[6] = -32'sh0001_0000;
        mt.hold = 1'b0;
        pending_mats.push_back(mt);
        foreach (mt.m[k]) mt.m[k] = 32'sh7FFF_FFFF;
        pending_mats.push_back(mt);
        for (int k = 0; k < 5; k++) add_random(k);
        for (int k = 0; k < 5; k++) add_random(0);

        // random: mostly moderate values, some full range, tiny or singular
        for (int n = 0; n < 700; n++) begin
            int roll;
            roll = $urandom_range(0, 99);
            if (roll < 25) add_random(0);
            else if (roll < 60) add_random(1);
            else if (roll < 75) add_random(2);
            else if (roll < 88) add_random(3);
            else add_random(4);
            if (n == 0 || n == 350) pending_mats[$].hold = 1'b1;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: advance on every taken transaction, idle in short random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            foreach (i_m[k]) i_m[k] <= '0;
            send_gap = 0;
            n_taken = 0;
            calm = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                inverse_q.push_back(invert(i_m));
                n_taken++;
            end
            calm = pending_mats.size() < 60;
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_mats.size() > 0 &&
                             !(pending_mats[0].hold && inverse_q.size() > 0)) begin
                    foreach (i_m[k]) i_m[k] <= pending_mats[0].m[k];
                    i_valid <= 1'b1;
                    void'(pending_mats.pop_front());
                    if (!calm && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 6);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result with the oldest prediction and drive
    // the receiver stall, including one long hold-off to back the pipe up.
    always @(posedge i_clk) begin
        m3i_pkg::t_res want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap = 0;
            hold_off_left = 0;
            hold_off_done = 1'b0;
            n_checked = 0;
            n_singular = 0;
            n_saturated = 0;
            n_errors = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (inverse_q.size() == 0) begin
                    $display("%0t: result with no matrix outstanding", $time);
                    n_errors++;
                end else begin
                    want = inverse_q.pop_front();
                    n_checked++;
                    if (want.singular) n_singular++;
                    for (int k = 0; k < m3i_pkg::NE; k++) begin
                        if (want.r[k] == m3i_pkg::SAT_POS || want.r[k] == m3i_pkg::SAT_NEG)
                            n_saturated++;
                        if (o_r[k] !== want.r[k]) begin
                            $display("%0t: r%0d%0d expected %h actual %h", $time,
                                     k / m3i_pkg::DIM, k % m3i_pkg::DIM, want.r[k], o_r[k]);
                            n_errors++;
                        end
                    end
                    if (o_singular !== want.singular) begin
                        $display("%0t: singular expected %b actual %b", $time,
                                 want.singular, o_singular);
                        n_errors++;
                    end
                end
            end
            if (!hold_off_done && n_taken >= 150) begin
                hold_off_left = 300;
                hold_off_done = 1'b1;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 5);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        wait (pending_mats.size() == 0 && inverse_q.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("Checked %0d inverses: %0d singular, %0d saturated elements.",
                 n_checked, n_singular, n_saturated);
        if (n_errors == 0 && inverse_q.size() == 0 && n_checked == n_taken)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/m3i_pkg.sv
sv/m3i_cof.sv
sv/m3i_det.sv
sv/m3i_div.sv
sv/matrix3_inverse.sv
test/testbench.sv
